// ----- hdl/masked_segment_quality_histogram_core_macros.svh -----
// assertion macros shared by the histogram core rtl
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef MASKED_SEGMENT_QUALITY_HISTOGRAM_CORE_MACROS_SVH
`define MASKED_SEGMENT_QUALITY_HISTOGRAM_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define MSQH_ASSERT_HOLD(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MSQH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/msqh_pkg.sv -----
// shared constants, codes and struct types of the segment quality histogram core
// no dependencies
`timescale 1ns / 1ps

package msqh_pkg;

    // storage sizes
    localparam int MAX_READS = 65536;
    localparam int SEEN_AW   = $clog2(MAX_READS);
    localparam int HIST_BINS = 101;
    localparam int HIST_AW   = $clog2(HIST_BINS);
    localparam int MAX_GAPS  = 16;
    localparam int GAP_AW    = $clog2(MAX_GAPS);
    localparam int GAP_CW    = $clog2(MAX_GAPS + 1);

    // field widths
    localparam int FUNC_W   = 2;
    localparam int ID_W     = 16;
    localparam int COORD_W  = 16;
    localparam int Q_W      = 8;
    localparam int BIN_W    = 7;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 48;
    localparam int WIDTH_W  = 11;
    localparam int TRIM_W   = 16;
    localparam int POS_W    = 17;
    localparam int W3_W     = 13;
    localparam int CMP_W    = 18;
    localparam int CFG_IW   = 1;
    localparam int CFG_DW   = 16;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 56;

    // algorithm constants
    localparam int Q_TOP      = 100;
    localparam int GAP_FACTOR = 3;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [POS_W-1:0]   POS_MAX   = '1;

    // register reset values
    localparam logic [WIDTH_W-1:0] SEG_WIDTH_RST = 11'd100;
    localparam logic [TRIM_W-1:0]  MIN_TRIM_RST  = 16'd1000;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_SEG_WIDTH = 1'd0;
    localparam logic [CFG_IW-1:0] CFG_MIN_TRIM  = 1'd1;

    // item kinds
    localparam logic [FUNC_W-1:0] FN_BEGIN  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REPEAT = 2'd1;
    localparam logic [FUNC_W-1:0] FN_QUAL   = 2'd2;
    localparam logic [FUNC_W-1:0] FN_HIST   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STS_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STS_IGNORED    = 3'd1;
    localparam logic [STATUS_W-1:0] STS_TRIM_SHORT = 3'd2;
    localparam logic [STATUS_W-1:0] STS_GAP_FULL   = 3'd3;
    localparam logic [STATUS_W-1:0] STS_ORDER      = 3'd4;

    // read-seen map access
    typedef struct packed {
        logic               rd_en;
        logic               wr_en;
        logic [SEEN_AW-1:0] addr;
    } seen_req_t;

    // histogram access
    typedef struct packed {
        logic               rd_en;
        logic               wr_en;
        logic [HIST_AW-1:0] addr;
        logic [COUNT_W-1:0] wr_data;
    } hist_req_t;

    // gap store write
    typedef struct packed {
        logic               en;
        logic [GAP_AW-1:0]  addr;
        logic [COORD_W-1:0] lo;
        logic [COORD_W-1:0] hi;
    } gap_wr_t;

    // segment position against the gap under the pointer
    typedef struct packed {
        logic past_end;
        logic in_margin;
    } gap_chk_t;

endpackage

// ----- hdl/masked_segment_quality_histogram_core.sv -----
// Segment quality histogram core. Reads arrive as a begin-read transfer, repeat transfers and
// quality transfers; quality values of segments that lie one segment width inside a unique gap
// of the trimmed read are counted into 101 saturating 48-bit bins, which a readback transfer
// returns. Every input transfer yields exactly one result transfer. Items are worked one at a
// time by a small sequencer around the read-seen map ram and the histogram ram, each with
// registered read data: an item answered without a memory access (a repeat item, an ignored
// or out-of-order item, a readback of a bin past the top) goes straight to its result, a
// begin-read item and an in-range readback first do a seen-map or histogram read, and a
// quality item walks its position past gaps and, when it is counted, does a histogram read,
// then an increment and write back. A result waits in an output register while the next item
// is taken; that item's result waits until the register has drained. After reset the
// 65536-entry read-seen map is swept to zero one entry a cycle, and no input is accepted until
// the sweep is over; configuration writes are taken at all times.
// depends on msqh_pkg, msqh_seen, msqh_hist, msqh_gap_store and the macros header
`timescale 1ns / 1ps
`include "masked_segment_quality_histogram_core_macros.svh"

module masked_segment_quality_histogram_core
    import msqh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // read_id[15:0], pos_begin[31:16], pos_end[47:32], q_value[55:48], bin_index[62:56]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // func[1:0]
    input  logic [FUNC_W-1:0]    s_tuser,
    // results
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // counted[0], bin_count[48:1]
    output logic [M_TDATA_W-1:0] m_tdata,
    // status[2:0]
    output logic [STATUS_W-1:0]  m_tuser,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IW-1:0]    cfg_index,
    input  logic [CFG_DW-1:0]    cfg_data
);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_SEEN  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_HINC  = 3'd4;
    localparam logic [2:0] ST_HREAD = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    // read phases
    localparam logic [1:0] PH_NONE   = 2'd0;
    localparam logic [1:0] PH_REPEAT = 2'd1;
    localparam logic [1:0] PH_QUAL   = 2'd2;
    localparam logic [1:0] PH_IGNORE = 2'd3;

    // configuration
    logic [WIDTH_W-1:0] seg_width_reg;
    logic [TRIM_W-1:0]  min_trim_reg;

    // control and read state
    logic [2:0]         state_reg, state_next;
    logic [1:0]         phase_reg, phase_next;
    logic               repeats_seen_reg, repeats_seen_next;
    logic [GAP_CW-1:0]  gap_count_reg, gap_count_next;
    logic [GAP_CW-1:0]  gap_ptr_reg, gap_ptr_next;
    logic [COORD_W-1:0] unique_start_reg, unique_start_next;
    logic [COORD_W-1:0] trim_start_reg, trim_start_next;
    logic [COORD_W-1:0] trim_stop_reg, trim_stop_next;
    logic [POS_W-1:0]   seg_pos_reg, seg_pos_next;

    // captured item
    logic [FUNC_W-1:0]  it_func_reg, it_func_next;
    logic [ID_W-1:0]    it_id_reg, it_id_next;
    logic [COORD_W-1:0] it_pb_reg, it_pb_next;
    logic [COORD_W-1:0] it_pe_reg, it_pe_next;
    logic [Q_W-1:0]     it_q_reg, it_q_next;
    logic [BIN_W-1:0]   it_bin_reg, it_bin_next;

    // result staging and output register
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                res_counted_reg, res_counted_next;
    logic [COUNT_W-1:0]  res_count_reg, res_count_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic                out_counted_reg, out_counted_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;

    // memory side
    seen_req_t          seen_req;
    logic               seen_bit;
    logic               seen_clear_done;
    hist_req_t          hist_req;
    logic [COUNT_W-1:0] hist_rd_data;
    gap_wr_t            gap_wr;
    gap_chk_t           gap_chk;

    // datapath helpers
    logic [W3_W-1:0]    width3;
    logic [COORD_W-1:0] rep_end;
    logic               rep_keep;
    logic               tail_keep;
    logic               trim_short;
    logic               gap_full;
    logic               ptr_live;
    logic               rid_in_range;
    logic               bin_in_range;
    logic [Q_W-1:0]     q_top;
    logic [Q_W-1:0]     q_clip;
    logic [HIST_AW-1:0] q_bin;
    logic [CMP_W-1:0]   seg_pos_sum;
    logic [POS_W-1:0]   seg_pos_adv;
    logic [COUNT_W-1:0] count_inc;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_width_reg <= SEG_WIDTH_RST;
            min_trim_reg  <= MIN_TRIM_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SEG_WIDTH: seg_width_reg <= cfg_data[WIDTH_W-1:0];
                CFG_MIN_TRIM:  min_trim_reg  <= cfg_data[TRIM_W-1:0];
                default:       seg_width_reg <= seg_width_reg;
            endcase
        end
    end

    // interval arithmetic, all unsigned with one guard bit
    assign width3     = W3_W'(seg_width_reg) * W3_W'(GAP_FACTOR);
    assign rep_end    = (it_pb_reg < trim_stop_reg) ? it_pb_reg : trim_stop_reg;
    assign rep_keep   = CMP_W'(rep_end) > (CMP_W'(unique_start_reg) + CMP_W'(width3));
    assign tail_keep  = CMP_W'(trim_stop_reg) > (CMP_W'(unique_start_reg) + CMP_W'(width3));
    assign trim_short = CMP_W'(it_pe_reg) < (CMP_W'(it_pb_reg) + CMP_W'(min_trim_reg));
    assign gap_full   = gap_count_reg >= GAP_CW'(MAX_GAPS);
    assign ptr_live   = gap_ptr_reg < gap_count_reg;

    assign rid_in_range = 32'(it_id_reg) < 32'(MAX_READS);
    assign bin_in_range = 32'(it_bin_reg) < 32'(HIST_BINS);

    // quality value to bin
    assign q_top  = (it_q_reg > Q_W'(Q_TOP)) ? Q_W'(Q_TOP) : it_q_reg;
    assign q_clip = (q_top > Q_W'(HIST_BINS - 1)) ? Q_W'(HIST_BINS - 1) : q_top;
    assign q_bin  = HIST_AW'(q_clip);

    // segment position step with saturation
    assign seg_pos_sum = CMP_W'(seg_pos_reg) + CMP_W'(seg_width_reg);
    assign seg_pos_adv = (seg_pos_sum > CMP_W'(POS_MAX)) ? POS_MAX : seg_pos_sum[POS_W-1:0];

    // saturating increment of the bin read back
    assign count_inc = (hist_rd_data == COUNT_MAX) ? COUNT_MAX : hist_rd_data + COUNT_W'(1);

    assign s_tready = (state_reg == ST_IDLE) && seen_clear_done;

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        repeats_seen_next = repeats_seen_reg;
        gap_count_next    = gap_count_reg;
        gap_ptr_next      = gap_ptr_reg;
        unique_start_next = unique_start_reg;
        trim_start_next   = trim_start_reg;
        trim_stop_next    = trim_stop_reg;
        seg_pos_next      = seg_pos_reg;
        it_func_next      = it_func_reg;
        it_id_next        = it_id_reg;
        it_pb_next        = it_pb_reg;
        it_pe_next        = it_pe_reg;
        it_q_next         = it_q_reg;
        it_bin_next       = it_bin_reg;
        res_status_next   = res_status_reg;
        res_counted_next  = res_counted_reg;
        res_count_next    = res_count_reg;
        out_valid_next    = out_valid_reg;
        out_status_next   = out_status_reg;
        out_counted_next  = out_counted_reg;
        out_count_next    = out_count_reg;

        seen_req.rd_en   = 1'b0;
        seen_req.wr_en   = 1'b0;
        seen_req.addr    = SEEN_AW'(it_id_reg);
        hist_req.rd_en   = 1'b0;
        hist_req.wr_en   = 1'b0;
        hist_req.addr    = q_bin;
        hist_req.wr_data = count_inc;
        gap_wr.en        = 1'b0;
        gap_wr.addr      = gap_count_reg[GAP_AW-1:0];
        gap_wr.lo        = unique_start_reg;
        gap_wr.hi        = trim_stop_reg;

        // output register drains on transfer
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    it_func_next = s_tuser;
                    it_id_next   = s_tdata[15:0];
                    it_pb_next   = s_tdata[31:16];
                    it_pe_next   = s_tdata[47:32];
                    it_q_next    = s_tdata[55:48];
                    it_bin_next  = s_tdata[62:56];
                    state_next   = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                res_status_next  = STS_OK;
                res_counted_next = 1'b0;
                res_count_next   = '0;
                state_next       = ST_DONE;
                case (it_func_reg)
                    FN_BEGIN:
                    begin
                        // open a new read, seen check follows
                        gap_count_next    = '0;
                        gap_ptr_next      = '0;
                        repeats_seen_next = 1'b0;
                        seg_pos_next      = '0;
                        trim_start_next   = it_pb_reg;
                        trim_stop_next    = it_pe_reg;
                        unique_start_next = it_pb_reg;
                        if (rid_in_range)
                        begin
                            seen_req.rd_en = 1'b1;
                            state_next     = ST_SEEN;
                        end
                        else
                        begin
                            res_status_next = STS_IGNORED;
                            phase_next      = PH_IGNORE;
                        end
                    end

                    FN_REPEAT:
                    begin
                        if (phase_reg == PH_IGNORE)
                        begin
                            res_status_next = STS_IGNORED;
                        end
                        else if (phase_reg != PH_REPEAT)
                        begin
                            res_status_next = STS_ORDER;
                        end
                        else
                        begin
                            // gap before this repeat
                            if (rep_keep)
                            begin
                                if (gap_full)
                                begin
                                    res_status_next = STS_GAP_FULL;
                                end
                                else
                                begin
                                    gap_wr.en      = 1'b1;
                                    gap_wr.hi      = rep_end;
                                    gap_count_next = gap_count_reg + GAP_CW'(1);
                                end
                            end
                            unique_start_next = (it_pe_reg > trim_start_reg) ? it_pe_reg
                                                                             : trim_start_reg;
                            repeats_seen_next = 1'b1;
                        end
                    end

                    FN_QUAL:
                    begin
                        if (phase_reg == PH_IGNORE)
                        begin
                            res_status_next = STS_IGNORED;
                        end
                        else if (phase_reg == PH_NONE)
                        begin
                            res_status_next = STS_ORDER;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                            // first quality item closes the gap list
                            if (phase_reg == PH_REPEAT)
                            begin
                                phase_next = PH_QUAL;
                                if (!repeats_seen_reg || tail_keep)
                                begin
                                    if (gap_full)
                                    begin
                                        res_status_next = STS_GAP_FULL;
                                    end
                                    else
                                    begin
                                        gap_wr.en      = 1'b1;
                                        gap_wr.lo      = repeats_seen_reg ? unique_start_reg
                                                                          : trim_start_reg;
                                        gap_count_next = gap_count_reg + GAP_CW'(1);
                                    end
                                end
                            end
                        end
                    end

                    FN_HIST:
                    begin
                        if (bin_in_range)
                        begin
                            hist_req.rd_en = 1'b1;
                            hist_req.addr  = HIST_AW'(it_bin_reg);
                            state_next     = ST_HREAD;
                        end
                    end

                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_SEEN:
            begin
                state_next = ST_DONE;
                if (seen_bit)
                begin
                    res_status_next = STS_IGNORED;
                    phase_next      = PH_IGNORE;
                end
                else
                begin
                    seen_req.wr_en = 1'b1;
                    if (trim_short)
                    begin
                        res_status_next = STS_TRIM_SHORT;
                        phase_next      = PH_IGNORE;
                    end
                    else
                    begin
                        phase_next = PH_REPEAT;
                    end
                end
            end

            ST_SCAN:
            begin
                // walk past gaps that end at or before the position
                if (ptr_live && gap_chk.past_end)
                begin
                    gap_ptr_next = gap_ptr_reg + GAP_CW'(1);
                end
                else if (ptr_live && gap_chk.in_margin)
                begin
                    hist_req.rd_en = 1'b1;
                    state_next     = ST_HINC;
                end
                else
                begin
                    seg_pos_next = seg_pos_adv;
                    state_next   = ST_DONE;
                end
            end

            ST_HINC:
            begin
                hist_req.wr_en   = 1'b1;
                res_counted_next = 1'b1;
                seg_pos_next     = seg_pos_adv;
                state_next       = ST_DONE;
            end

            ST_HREAD:
            begin
                res_count_next = hist_rd_data;
                state_next     = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = res_status_reg;
                    out_counted_next = res_counted_reg;
                    out_count_next   = res_count_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            phase_reg        <= PH_NONE;
            repeats_seen_reg <= 1'b0;
            gap_count_reg    <= '0;
            gap_ptr_reg      <= '0;
            unique_start_reg <= '0;
            trim_start_reg   <= '0;
            trim_stop_reg    <= '0;
            seg_pos_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            repeats_seen_reg <= repeats_seen_next;
            gap_count_reg    <= gap_count_next;
            gap_ptr_reg      <= gap_ptr_next;
            unique_start_reg <= unique_start_next;
            trim_start_reg   <= trim_start_next;
            trim_stop_reg    <= trim_stop_next;
            seg_pos_reg      <= seg_pos_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        it_func_reg     <= it_func_next;
        it_id_reg       <= it_id_next;
        it_pb_reg       <= it_pb_next;
        it_pe_reg       <= it_pe_next;
        it_q_reg        <= it_q_next;
        it_bin_reg      <= it_bin_next;
        res_status_reg  <= res_status_next;
        res_counted_reg <= res_counted_next;
        res_count_reg   <= res_count_next;
        out_status_reg  <= out_status_next;
        out_counted_reg <= out_counted_next;
        out_count_reg   <= out_count_next;
    end

    // memories and gap store
    msqh_seen u_seen (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (seen_req),
        .rd_bit     (seen_bit),
        .clear_done (seen_clear_done)
    );

    msqh_hist u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (hist_req),
        .rd_data (hist_rd_data)
    );

    msqh_gap_store u_gaps (
        .clk       (clk),
        .wr        (gap_wr),
        .rd_ptr    (gap_ptr_reg[GAP_AW-1:0]),
        .seg_pos   (seg_pos_reg),
        .seg_width (seg_width_reg),
        .chk       (gap_chk)
    );

    // result ports
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - COUNT_W - 1){1'b0}}, out_count_reg, out_counted_reg};
    assign m_tuser  = out_status_reg;

    // checks
    `MSQH_ASSERT_HOLD(a_gap_count_bound, 1'b1, gap_count_reg <= GAP_CW'(MAX_GAPS), "gap count overflow")
    `MSQH_ASSERT_HOLD(a_scan_ptr_bound, state_reg == ST_SCAN, gap_ptr_reg <= gap_count_reg, "gap pointer past count")
    `MSQH_ASSERT_NEXT(a_scan_step, (state_reg == ST_SCAN) && ptr_live && gap_chk.past_end, gap_ptr_reg == $past(gap_ptr_reg) + GAP_CW'(1), "gap walk did not advance")
    `MSQH_ASSERT_HOLD(a_hist_rmw, hist_req.wr_en, $past(hist_req.rd_en) && ($past(hist_req.addr) == hist_req.addr), "histogram write without matching read")
    `MSQH_ASSERT_HOLD(a_seen_after_clear, seen_req.rd_en || seen_req.wr_en, seen_clear_done, "seen map used during clearing pass")

endmodule

// ----- hdl/msqh_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module msqh_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/msqh_seen.sv -----
// read-seen map: one bit per read id in a ram, swept to zero after reset
// depends on msqh_pkg and msqh_ram
`timescale 1ns / 1ps

module msqh_seen
    import msqh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  seen_req_t req,
    output logic      rd_bit,
    output logic      clear_done
);

    logic [SEEN_AW:0]   clr_cnt_reg;
    logic [SEEN_AW:0]   clr_cnt_next;
    logic               ram_we;
    logic [SEEN_AW-1:0] ram_waddr;
    logic [0:0]         ram_wdata;
    logic [0:0]         ram_rdata;

    // clearing pass counter, top bit set when the sweep is over
    assign clear_done   = clr_cnt_reg[SEEN_AW];
    assign clr_cnt_next = clear_done ? clr_cnt_reg : clr_cnt_reg + (SEEN_AW + 1)'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // sweep writes zero, normal writes mark the id as seen
    assign ram_we    = !clear_done || req.wr_en;
    assign ram_waddr = clear_done ? req.addr : clr_cnt_reg[SEEN_AW-1:0];
    assign ram_wdata = clear_done ? 1'b1 : 1'b0;

    msqh_ram #(
        .DEPTH (MAX_READS),
        .WIDTH (1)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (req.rd_en),
        .raddr (req.addr),
        .rdata (ram_rdata)
    );

    assign rd_bit = ram_rdata[0];

endmodule

// ----- hdl/msqh_hist.sv -----
// histogram counts in a ram, with per-bin valid flops so reset reads as zero
// depends on msqh_pkg and msqh_ram
`timescale 1ns / 1ps

module msqh_hist
    import msqh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  hist_req_t          req,
    output logic [COUNT_W-1:0] rd_data
);

    logic [HIST_BINS-1:0] bin_vld_reg;
    logic                 rd_vld_reg;
    logic [COUNT_W-1:0]   ram_rdata;

    // a bin becomes valid on its first write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_vld_reg <= '0;
        end
        else if (req.wr_en)
        begin
            bin_vld_reg[req.addr] <= 1'b1;
        end
    end

    // valid flag travels with the registered read
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_vld_reg <= bin_vld_reg[req.addr];
        end
    end

    msqh_ram #(
        .DEPTH (HIST_BINS),
        .WIDTH (COUNT_W)
    ) u_ram (
        .clk   (clk),
        .we    (req.wr_en),
        .waddr (req.addr),
        .wdata (req.wr_data),
        .re    (req.rd_en),
        .raddr (req.addr),
        .rdata (ram_rdata)
    );

    assign rd_data = rd_vld_reg ? ram_rdata : '0;

endmodule

// ----- hdl/msqh_gap_store.sv -----
// unique gap bounds of the open read and the position test against one gap
// depends on msqh_pkg
`timescale 1ns / 1ps

module msqh_gap_store
    import msqh_pkg::*;
(
    input  logic               clk,
    input  gap_wr_t            wr,
    input  logic [GAP_AW-1:0]  rd_ptr,
    input  logic [POS_W-1:0]   seg_pos,
    input  logic [WIDTH_W-1:0] seg_width,
    output gap_chk_t           chk
);

    logic [COORD_W-1:0] gap_lo_reg [MAX_GAPS];
    logic [COORD_W-1:0] gap_hi_reg [MAX_GAPS];
    logic [COORD_W-1:0] cur_lo;
    logic [COORD_W-1:0] cur_hi;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   lo_margin;
    logic [CMP_W-1:0]   pos_margin;

    // gap writes
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            gap_lo_reg[wr.addr] <= wr.lo;
            gap_hi_reg[wr.addr] <= wr.hi;
        end
    end

    assign cur_lo = gap_lo_reg[rd_ptr];
    assign cur_hi = gap_hi_reg[rd_ptr];

    // position at or past the gap end, or at least one width inside both bounds
    assign pos_ext    = CMP_W'(seg_pos);
    assign lo_margin  = CMP_W'(cur_lo) + CMP_W'(seg_width);
    assign pos_margin = pos_ext + CMP_W'(seg_width);

    assign chk.past_end  = pos_ext >= CMP_W'(cur_hi);
    assign chk.in_margin = (pos_ext >= lo_margin) && (pos_margin <= CMP_W'(cur_hi));

endmodule
